[design/brainfuck_instruction_unit_defines.svh]
// Assertion macros used by the brainfuck instruction unit checker.
`ifndef BRAINFUCK_INSTRUCTION_UNIT_DEFINES_SVH
`define BRAINFUCK_INSTRUCTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BFIU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfiu: property violated");

// Next-cycle implication, disabled while reset is low.
`define BFIU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfiu: property violated");

// Next-cycle implication that also holds through reset.
`define BFIU_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bfiu: property violated");

`endif

[design/bfiu_pkg.sv]
// Shared constants, codes and defaults for the brainfuck instruction unit.
package bfiu_pkg;

    localparam int TAPE_SIZE_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int POS_WIDTH_DEF   = 16;

    // Program characters that act
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_RIGHT = 8'h3E;
    localparam logic [7:0] CH_LEFT  = 8'h3C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        ACT_CONT = 2'd0,
        ACT_OUT  = 2'd1,
        ACT_JUMP = 2'd2,
        ACT_ERR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } err_kind_t;

endpackage

[design/brainfuck_instruction_unit.sv]
// Brainfuck instruction unit: executes one program character per input word.
// Usage:
//   Slave channel (s_*): one program character per word, with its position and the
//   byte that ',' stores. Master channel (m_*): exactly one result word per input word,
//   in order: continue, output byte, jump to a loop body, or error.
// Throughput: one word per cycle, sustained while m_tready stays high. The tape memory
//   is read when a word is accepted and written back in the execute stage; a write to
//   the cell the next word reads is forwarded. The loop stack memory is read and
//   forwarded the same way.
// Order: an accepted word is registered in the execute stage, and its result is
//   registered in the result register that drives the master channel.
// Reset: aresetn low for one edge restarts the block. After reset the tape is cleared by
//   a sweep over all TAPE_SIZE cells (4096 by default) with s_tready low; pointer, stack and
//   skip depth start at zero.
// Stall: while the result register waits on m_tready, one more word is still taken into
//   the execute stage; then s_tready drops until the result is taken.
module brainfuck_instruction_unit #(
    parameter int TAPE_SIZE   = bfiu_pkg::TAPE_SIZE_DEF,
    parameter int STACK_DEPTH = bfiu_pkg::STACK_DEPTH_DEF,
    parameter int POS_WIDTH   = bfiu_pkg::POS_WIDTH_DEF,
    localparam int S_DATA_W   = ((16 + POS_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W   = ((8 + POS_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // instr_char[7:0], instr_pos[POS_WIDTH-1:0], read_value[7:0], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_byte[7:0], jump_pos[POS_WIDTH-1:0], zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // action[1:0], error_kind[1:0]
    output logic [3:0]          m_tuser
);

    localparam int TP_W = $clog2(TAPE_SIZE);
    localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SC_W = $clog2(STACK_DEPTH + 1);
    localparam logic [TP_W-1:0] TP_LAST = TP_W'(TAPE_SIZE - 1);
    localparam logic [SC_W-1:0] SC_FULL = SC_W'(STACK_DEPTH);

    // Input word fields
    logic [7:0]           s_char;
    logic [POS_WIDTH-1:0] s_pos;
    logic [7:0]           s_rd;

    assign s_char = s_tdata[7:0];
    assign s_pos  = s_tdata[8 +: POS_WIDTH];
    assign s_rd   = s_tdata[8 + POS_WIDTH +: 8];

    // Tape clearing sweep after reset
    logic            clr_active_reg;
    logic [TP_W-1:0] clr_addr_reg;

    // Architectural state
    logic [TP_W-1:0] ptr_reg, ptr_next;
    logic [SC_W-1:0] stk_cnt_reg, stk_cnt_next;
    logic [SC_W-1:0] skip_reg, skip_next;

    // Execute stage
    logic                 s1_valid_reg;
    logic [7:0]           s1_char_reg;
    logic [POS_WIDTH-1:0] s1_pos_reg;
    logic [7:0]           s1_rd_reg;

    // Tape memory, read data and forwarding
    logic [7:0]      tape_mem [TAPE_SIZE];
    logic [7:0]      tape_q_reg;
    logic            tfwd_valid_reg;
    logic [7:0]      tfwd_data_reg;
    logic            tape_we;
    logic [TP_W-1:0] tape_waddr;
    logic [7:0]      tape_wdata;
    logic [TP_W-1:0] tape_raddr;
    logic [7:0]      cell_val;

    // Loop stack memory, read data and forwarding
    logic [POS_WIDTH-1:0] stk_mem [STACK_DEPTH];
    logic [POS_WIDTH-1:0] stk_q_reg;
    logic                 sfwd_valid_reg;
    logic [POS_WIDTH-1:0] sfwd_data_reg;
    logic                 stk_we;
    logic [SA_W-1:0]      stk_waddr;
    logic [SA_W-1:0]      stk_raddr;
    logic [SC_W-1:0]      stk_cnt_eff;
    logic [SC_W-1:0]      stk_cnt_m1;
    logic [POS_WIDTH-1:0] stk_top;

    // Result register
    logic                 m_valid_reg;
    bfiu_pkg::action_t    m_action_reg, m_action_next;
    logic [7:0]           m_byte_reg, m_byte_next;
    logic [POS_WIDTH-1:0] m_jump_reg, m_jump_next;
    bfiu_pkg::err_kind_t  m_err_reg, m_err_next;

    // Execute decisions
    logic       exec_fire;
    logic       in_fire;
    logic       exec_tape_we;
    logic [7:0] exec_wdata;
    logic       exec_push;

    assign exec_fire = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !clr_active_reg && (!s1_valid_reg || exec_fire);
    assign in_fire   = s_tvalid && s_tready;

    // Take the just-written value when the previous execute hit the entry being read
    assign cell_val = tfwd_valid_reg ? tfwd_data_reg : tape_q_reg;
    assign stk_top  = sfwd_valid_reg ? sfwd_data_reg : stk_q_reg;

    always_comb begin
        ptr_next      = ptr_reg;
        stk_cnt_next  = stk_cnt_reg;
        skip_next     = skip_reg;
        exec_tape_we  = 1'b0;
        exec_wdata    = cell_val;
        exec_push     = 1'b0;
        m_action_next = bfiu_pkg::ACT_CONT;
        m_byte_next   = 8'd0;
        m_jump_next   = '0;
        m_err_next    = bfiu_pkg::ERR_NONE;
        if (skip_reg != '0) begin
            // Skipping a loop body: track bracket nesting only, with an overflow error when full
            case (s1_char_reg)
                bfiu_pkg::CH_OPEN: begin
                    if (skip_reg >= SC_FULL) begin
                        m_action_next = bfiu_pkg::ACT_ERR;
                        m_err_next    = bfiu_pkg::ERR_OVERFLOW;
                    end else begin
                        skip_next = skip_reg + SC_W'(1);
                    end
                end
                bfiu_pkg::CH_CLOSE: begin
                    skip_next = skip_reg - SC_W'(1);
                end
                default: begin
                end
            endcase
        end else begin
            case (s1_char_reg)
                bfiu_pkg::CH_PLUS: begin
                    exec_tape_we = 1'b1;
                    exec_wdata   = cell_val + 8'd1;
                end
                bfiu_pkg::CH_MINUS: begin
                    exec_tape_we = 1'b1;
                    exec_wdata   = cell_val - 8'd1;
                end
                bfiu_pkg::CH_RIGHT: begin
                    ptr_next = (ptr_reg == TP_LAST) ? '0 : ptr_reg + TP_W'(1);
                end
                bfiu_pkg::CH_LEFT: begin
                    ptr_next = (ptr_reg == '0) ? TP_LAST : ptr_reg - TP_W'(1);
                end
                bfiu_pkg::CH_DOT: begin
                    m_action_next = bfiu_pkg::ACT_OUT;
                    m_byte_next   = cell_val;
                end
                bfiu_pkg::CH_COMMA: begin
                    exec_tape_we = 1'b1;
                    exec_wdata   = s1_rd_reg;
                end
                bfiu_pkg::CH_OPEN: begin
                    if (cell_val == 8'd0) begin
                        skip_next = SC_W'(1);
                    end else if (stk_cnt_reg >= SC_FULL) begin
                        m_action_next = bfiu_pkg::ACT_ERR;
                        m_err_next    = bfiu_pkg::ERR_OVERFLOW;
                    end else begin
                        exec_push    = 1'b1;
                        stk_cnt_next = stk_cnt_reg + SC_W'(1);
                    end
                end
                bfiu_pkg::CH_CLOSE: begin
                    if (stk_cnt_reg == '0) begin
                        m_action_next = bfiu_pkg::ACT_ERR;
                        m_err_next    = bfiu_pkg::ERR_UNMATCHED;
                    end else if (cell_val != 8'd0) begin
                        m_action_next = bfiu_pkg::ACT_JUMP;
                        m_jump_next   = stk_top + POS_WIDTH'(1);
                    end else begin
                        stk_cnt_next = stk_cnt_reg - SC_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Memory port selection: the sweep owns the tape write port while it runs
    always_comb begin
        tape_we     = clr_active_reg || (exec_fire && exec_tape_we);
        tape_waddr  = clr_active_reg ? clr_addr_reg : ptr_reg;
        tape_wdata  = clr_active_reg ? 8'd0 : exec_wdata;
        tape_raddr  = exec_fire ? ptr_next : ptr_reg;
        stk_we      = exec_fire && exec_push;
        stk_waddr   = stk_cnt_reg[SA_W-1:0];
        stk_cnt_eff = exec_fire ? stk_cnt_next : stk_cnt_reg;
        stk_cnt_m1  = stk_cnt_eff - SC_W'(1);
        stk_raddr   = stk_cnt_m1[SA_W-1:0];
    end

    // Tape memory
    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        if (in_fire) begin
            tape_q_reg     <= tape_mem[tape_raddr];
            tfwd_valid_reg <= tape_we && (tape_waddr == tape_raddr);
            tfwd_data_reg  <= tape_wdata;
        end
    end

    // Loop stack memory
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= s1_pos_reg;
        end
        if (in_fire) begin
            stk_q_reg      <= stk_mem[stk_raddr];
            sfwd_valid_reg <= stk_we && (stk_waddr == stk_raddr);
            sfwd_data_reg  <= s1_pos_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            ptr_reg        <= '0;
            stk_cnt_reg    <= '0;
            skip_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + TP_W'(1);
                if (clr_addr_reg == TP_LAST) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (exec_fire) begin
                ptr_reg     <= ptr_next;
                stk_cnt_reg <= stk_cnt_next;
                skip_reg    <= skip_next;
            end
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Execute-stage and result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_char_reg <= s_char;
            s1_pos_reg  <= s_pos;
            s1_rd_reg   <= s_rd;
        end
        if (exec_fire) begin
            m_action_reg <= m_action_next;
            m_byte_reg   <= m_byte_next;
            m_jump_reg   <= m_jump_next;
            m_err_reg    <= m_err_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_err_reg, m_action_reg};

    always_comb begin
        m_tdata                  = '0;
        m_tdata[7:0]             = m_byte_reg;
        m_tdata[8 +: POS_WIDTH]  = m_jump_reg;
    end

endmodule

[design/bfiu_checker.sv]
// Port-level checker for the brainfuck instruction unit, with its bind.
`include "brainfuck_instruction_unit_defines.svh"

module bfiu_checker #(
    parameter int POS_WIDTH  = bfiu_pkg::POS_WIDTH_DEF,
    localparam int M_DATA_W  = ((8 + POS_WIDTH + 7) / 8) * 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [3:0]          m_tuser
);

    // Hold a stalled result word
    `BFIU_ASSERT_NXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Tape sweep keeps the slave side closed right after reset
    `BFIU_ASSERT_NXT_ALWAYS(a_sweep_after_reset, aclk, !aresetn, !s_tready)

    // An error word carries a real error kind
    `BFIU_ASSERT_IMP(a_error_kind, aclk, aresetn, m_tvalid && (m_tuser[1:0] == bfiu_pkg::ACT_ERR), (m_tuser[3:2] == bfiu_pkg::ERR_OVERFLOW) || (m_tuser[3:2] == bfiu_pkg::ERR_UNMATCHED))

    // Only an output word carries a byte
    `BFIU_ASSERT_IMP(a_byte_only_on_out, aclk, aresetn, m_tvalid && (m_tuser[1:0] != bfiu_pkg::ACT_OUT), m_tdata[7:0] == 8'd0)

endmodule

bind brainfuck_instruction_unit bfiu_checker #(
    .POS_WIDTH(POS_WIDTH)
) u_bfiu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
